// ===== src/assert_macros.svh =====
// Assertion macros shared by the cache set RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/lcsw_pkg.sv =====
// Shared types and constants of the cache set.
`timescale 1ns / 1ps
package lcsw_pkg;

   localparam int WAYS_DEFAULT     = 8;
   localparam int TAG_BITS_DEFAULT = 52;

   localparam int REQ_TAG_W = 52;
   localparam int RSP_TAG_W = 52;
   localparam int WAY_OUT_W = 3;
   localparam int CFG_W     = 4;

   localparam logic [CFG_W-1:0] CFG_WAYS_RESET = 4'd8;

   typedef enum logic {
      MODE_READ  = 1'b0,
      MODE_WRITE = 1'b1
   } mode_type;

   // Outcome of one lookup: exactly one of the three is set.
   typedef struct packed {
      logic hit;
      logic fill;
      logic evict;
   } lookup_flags_type;

endpackage

// ===== src/lcsw_chan_if.sv =====
// Request and response channel interfaces of the cache set.
`timescale 1ns / 1ps
interface lcsw_req_if;
   import lcsw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [REQ_TAG_W-1:0] tag;

   modport source (output valid, output mode, output tag, input ready);
   modport sink   (input valid, input mode, input tag, output ready);
endinterface

interface lcsw_rsp_if;
   import lcsw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way;
   logic                 evicted;
   logic                 write_back;
   logic [RSP_TAG_W-1:0] victim_tag;

   modport source (output valid, output hit, output way, output evicted,
                   output write_back, output victim_tag, input ready);
   modport sink   (input valid, input hit, input way, input evicted,
                   input write_back, input victim_tag, output ready);
endinterface

// ===== src/lru_cache_set_writeback_core.sv =====
// Top level of one write-back, write-allocate cache set with LRU replacement.
// A request is held in the request register; its response is registered in the response register.
// Throughput: one request per cycle while responses are taken, since the combinational tag
// compare and recency update run between the request register and the response register.
// Reset clears the dirty bits, recency ranks and fill count, and sets ways_in_use to
// min(8, WAYS); stored tags are not reset and are only read once their way is filled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_cache_set_writeback_core #(
   parameter int WAYS     = lcsw_pkg::WAYS_DEFAULT,
   parameter int TAG_BITS = lcsw_pkg::TAG_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   lcsw_req_if.sink                    req_chan,
   lcsw_rsp_if.source                  rsp_chan,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lcsw_pkg::CFG_W-1:0]  csr_data
);
   import lcsw_pkg::*;

   localparam int WayW = $clog2(WAYS);
   localparam int CntW = $clog2(WAYS + 1);
   localparam int LimitReset = (int'(CFG_WAYS_RESET) > WAYS) ? WAYS : int'(CFG_WAYS_RESET);

   // The request register holds one request. It moves on when the response
   // register is empty or is being drained in the same cycle, so a new request
   // can enter every cycle while the pipe flows.
   logic                in_valid_ff;
   logic                in_mode_ff;
   logic [TAG_BITS-1:0] in_tag_ff;
   logic                advance;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;
   logic                 rsp_evicted_ff;
   logic                 rsp_write_back_ff;
   logic [RSP_TAG_W-1:0] rsp_victim_tag_ff;

   // Set state. Tags carry no reset; the fill count guards every read of them.
   logic [TAG_BITS-1:0] tag_ff   [WAYS];
   logic [TAG_BITS-1:0] tag_in   [WAYS];
   logic [WAYS-1:0]     dirty_ff;
   logic [WAYS-1:0]     dirty_in;
   logic [WayW-1:0]     rank_ff  [WAYS];
   logic [WayW-1:0]     rank_in  [WAYS];
   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;

   // The ways_in_use register is kept already clamped to 1..WAYS.
   logic [CntW-1:0]     limit_ff;
   logic [CntW-1:0]     limit_in;

   logic [WayW-1:0]     sel_way;
   lookup_flags_type    flags;
   logic [CntW-1:0]     touch_rank;
   logic                is_write;

   assign advance          = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign csr_ready        = 1'b1;
   assign is_write         = (in_mode_ff == MODE_WRITE);

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_mode_ff <= req_chan.mode;
         in_tag_ff  <= TAG_BITS'(req_chan.tag);
      end
   end

   // A zero setting acts as one way, and a setting above the way count as all ways.
   always_comb begin
      if (csr_data == '0) begin
         limit_in = CntW'(1);
      end else if (int'(csr_data) > WAYS) begin
         limit_in = CntW'(WAYS);
      end else begin
         limit_in = CntW'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CntW'(LimitReset);
      end else if (csr_valid && csr_ready) begin
         limit_ff <= limit_in;
      end
   end

   lcsw_lookup #(
      .WAYS     (WAYS),
      .TAG_BITS (TAG_BITS)
   ) u_lookup (
      .tag_q      (in_tag_ff),
      .line_tags  (tag_ff),
      .line_ranks (rank_ff),
      .fill_count (count_ff),
      .ways_limit (limit_ff),
      .sel_way    (sel_way),
      .flags      (flags)
   );

   // The selected way becomes most recent. Filled ways that were more recent
   // than it age by one. A fill treats the new way as older than every filled
   // way, so all filled ways age.
   assign touch_rank = flags.fill ? count_ff : CntW'(rank_ff[sel_way]);

   always_comb begin
      tag_in   = tag_ff;
      dirty_in = dirty_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      for (int i = 0; i < WAYS; i++) begin
         if ((CntW'(i) < count_ff) && (WayW'(i) != sel_way)
             && (CntW'(rank_ff[i]) < touch_rank)) begin
            rank_in[i] = rank_ff[i] + WayW'(1);
         end
      end
      rank_in[sel_way] = '0;
      if (flags.hit) begin
         dirty_in[sel_way] = dirty_ff[sel_way] | is_write;
      end else begin
         dirty_in[sel_way] = is_write;
         tag_in[sel_way]   = in_tag_ff;
      end
      if (flags.fill) begin
         count_in = count_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < WAYS; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (advance) begin
         dirty_ff <= dirty_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff <= tag_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff        <= flags.hit;
         rsp_way_ff        <= WAY_OUT_W'(sel_way);
         rsp_evicted_ff    <= flags.evict;
         rsp_write_back_ff <= flags.evict && dirty_ff[sel_way];
         rsp_victim_tag_ff <= flags.evict ? RSP_TAG_W'(tag_ff[sel_way]) : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.way        = rsp_way_ff;
   assign rsp_chan.evicted    = rsp_evicted_ff;
   assign rsp_chan.write_back = rsp_write_back_ff;
   assign rsp_chan.victim_tag = rsp_victim_tag_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, int'(count_ff) <= WAYS, "fill count above way count")
   `ASSERT_SAME(a_wb_needs_evict, clock, reset, rsp_valid_ff && rsp_write_back_ff, rsp_evicted_ff && !rsp_hit_ff, "write-back without eviction")
   `ASSERT_NEXT(a_fill_counts, clock, reset, advance && flags.fill, count_ff == $past(count_ff) + CntW'(1), "fill did not grow the set")
   `ASSERT_NEXT(a_touch_newest, clock, reset, advance, rank_ff[$past(sel_way)] == '0, "accessed way is not most recent")
   `ASSERT_SAME(a_one_outcome, clock, reset, in_valid_ff, $onehot(flags), "lookup outcome not unique")

endmodule

// ===== src/lcsw_lookup.sv =====
// Tag match, fill check and least-recent victim search over the set.
`timescale 1ns / 1ps
module lcsw_lookup #(
   parameter int WAYS     = lcsw_pkg::WAYS_DEFAULT,
   parameter int TAG_BITS = lcsw_pkg::TAG_BITS_DEFAULT
) (
   input  logic [TAG_BITS-1:0]                 tag_q,
   input  logic [TAG_BITS-1:0]                 line_tags  [WAYS],
   input  logic [$clog2(WAYS)-1:0]             line_ranks [WAYS],
   input  logic [$clog2(WAYS+1)-1:0]           fill_count,
   input  logic [$clog2(WAYS+1)-1:0]           ways_limit,
   output logic [$clog2(WAYS)-1:0]             sel_way,
   output lcsw_pkg::lookup_flags_type          flags
);
   import lcsw_pkg::*;

   localparam int WayW = $clog2(WAYS);
   localparam int CntW = $clog2(WAYS + 1);

   logic [WAYS-1:0] match;
   logic [WAYS-1:0] oldest;
   logic [CntW-1:0] last_rank;
   logic [WayW-1:0] hit_way;
   logic [WayW-1:0] victim_way;
   logic            any_hit;
   logic            full;

   assign last_rank = fill_count - CntW'(1);
   assign full      = (fill_count >= ways_limit);

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         match[i]  = (CntW'(i) < fill_count) && (line_tags[i] == tag_q);
         oldest[i] = (CntW'(i) < fill_count) && (line_ranks[i] == last_rank[WayW-1:0]);
      end
   end

   // Lowest index wins in both searches.
   always_comb begin
      hit_way    = '0;
      victim_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way = WayW'(i);
         end
         if (oldest[i]) begin
            victim_way = WayW'(i);
         end
      end
   end

   assign any_hit = |match;

   always_comb begin
      flags.hit   = any_hit;
      flags.fill  = !any_hit && !full;
      flags.evict = !any_hit && full;
      if (any_hit) begin
         sel_way = hit_way;
      end else if (full) begin
         sel_way = victim_way;
      end else begin
         sel_way = fill_count[WayW-1:0];
      end
   end

endmodule
